>>> src/iol_pkg.sv
// ----------------------------------------------------------------------------
// iol_pkg: shared types and constants for the indexed ordered list
// Command and status codes, the decoded request format that travels from
// the front end through the queue to the back end, and state encodings.
// ----------------------------------------------------------------------------
`default_nettype none

package iol_pkg;

    localparam int CAPACITY_DEF = 256;
    localparam int QUEUE_DEPTH  = 2;

    localparam int CMD_W = 3;
    localparam int POS_W = 9;
    localparam int VAL_W = 32;
    localparam int ST_W  = 2;
    localparam int LEN_W = 9;

    localparam logic [CMD_W-1:0] CMD_INS_HEAD = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INS_TAIL = 3'd1;
    localparam logic [CMD_W-1:0] CMD_INS_POS  = 3'd2;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ     = 3'd4;

    localparam logic [ST_W-1:0] STAT_OK    = 2'd0;
    localparam logic [ST_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [ST_W-1:0] STAT_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_INSERT,
        OP_DELETE,
        OP_READ,
        OP_BAD
    } op_t;

    // Where an insert lands: the given position, the head or the tail.
    typedef enum logic [1:0] {
        SEL_POS,
        SEL_HEAD,
        SEL_TAIL
    } sel_t;

    typedef struct packed {
        op_t                     op;
        sel_t                    sel;
        logic [POS_W-1:0]        position;
        logic signed [VAL_W-1:0] value;
    } req_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SHIFT,
        BK_DRAIN,
        BK_PUT,
        BK_RWAIT,
        BK_DONE
    } bk_state_t;

endpackage

`default_nettype wire

>>> src/iol_front.sv
// ----------------------------------------------------------------------------
// iol_front: command intake
// Accepts input transfers and decodes each command into a request for the
// queue. Takes a new transfer whenever the queue has room.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_front
    import iol_pkg::*;
(
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [CMD_W-1:0]        s_command,
    input  wire logic [POS_W-1:0]        s_position,
    input  wire logic signed [VAL_W-1:0] s_value,
    input  wire logic                    q_full,
    output logic                         push,
    output req_t                         push_req
);

    assign s_ready = !q_full;
    assign push    = s_valid && !q_full;

    always_comb begin
        push_req.position = s_position;
        push_req.value    = s_value;
        push_req.sel      = SEL_POS;
        unique case (s_command)
            CMD_INS_HEAD: begin
                push_req.op  = OP_INSERT;
                push_req.sel = SEL_HEAD;
            end
            CMD_INS_TAIL: begin
                push_req.op  = OP_INSERT;
                push_req.sel = SEL_TAIL;
            end
            CMD_INS_POS:  push_req.op = OP_INSERT;
            CMD_DELETE:   push_req.op = OP_DELETE;
            CMD_READ:     push_req.op = OP_READ;
            default:      push_req.op = OP_BAD;
        endcase
    end

endmodule

`default_nettype wire

>>> src/iol_queue.sv
// ----------------------------------------------------------------------------
// iol_queue: request queue
// A short first-in first-out queue of decoded requests between the front
// end and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_queue
    import iol_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire req_t push_req,
    output logic      full,
    output logic      out_valid,
    output req_t      out_req,
    input  wire logic pop
);

    localparam int DEPTH = QUEUE_DEPTH;
    localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int FW    = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
    localparam logic [FW-1:0] FULL_FILL = FW'(DEPTH);

    req_t            slot_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FW-1:0]   fill_reg, fill_next;
    logic            do_push, do_pop;

    assign full      = (fill_reg == FULL_FILL);
    assign out_valid = (fill_reg != '0);
    assign out_req   = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && out_valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PW'(1);
        end
        if (do_push && !do_pop) begin
            fill_next = fill_reg + FW'(1);
        end else if (do_pop && !do_push) begin
            fill_next = fill_reg - FW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

`default_nettype wire

>>> src/iol_back.sv
// ----------------------------------------------------------------------------
// iol_back: list engine
// Holds the entry memory and the length, carries out one request at a time
// and drives the result register. Inserts and deletes move the affected
// entries one per cycle through a read-then-write pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_back
    import iol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    q_valid,
    input  wire req_t                    q_req,
    output logic                         q_pop,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [VAL_W-1:0]      m_read_value,
    output logic [ST_W-1:0]              m_status,
    output logic [LEN_W-1:0]             m_length
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = (CW > POS_W) ? CW : POS_W;
    localparam logic [CW-1:0] CAP_CNT = CW'(CAPACITY);

    logic [VAL_W-1:0]        mem [CAPACITY];
    logic [VAL_W-1:0]        rdata_reg;

    bk_state_t               state_reg, state_next;
    logic [CW-1:0]           count_reg, count_next;
    logic [AW-1:0]           rd_reg, rd_next;
    logic [AW-1:0]           pos_reg, pos_next;
    logic signed [VAL_W-1:0] value_reg, value_next;
    logic                    is_ins_reg, is_ins_next;
    logic                    pend_reg, pend_next;
    logic [AW-1:0]           pend_addr_reg, pend_addr_next;
    logic signed [VAL_W-1:0] res_value_reg, res_value_next;
    logic [ST_W-1:0]         res_status_reg, res_status_next;
    logic                    m_valid_reg, m_valid_next;
    logic signed [VAL_W-1:0] m_value_reg, m_value_next;
    logic [ST_W-1:0]         m_status_reg, m_status_next;
    logic [LEN_W-1:0]        m_length_reg, m_length_next;

    logic                    mem_re, mem_we;
    logic [AW-1:0]           mem_raddr, mem_waddr;
    logic [VAL_W-1:0]        mem_wdata;

    logic [XW-1:0]           count_x, req_pos_x, req_pos_p1;
    logic [CW-1:0]           count_m1;

    assign count_x  = XW'(count_reg);
    assign count_m1 = count_reg - CW'(1);
    assign req_pos_p1 = req_pos_x + XW'(1);

    always_comb begin
        case (q_req.sel)
            SEL_HEAD: req_pos_x = '0;
            SEL_TAIL: req_pos_x = count_x;
            default:  req_pos_x = XW'(q_req.position);
        endcase
    end

    assign m_valid      = m_valid_reg;
    assign m_read_value = m_value_reg;
    assign m_status     = m_status_reg;
    assign m_length     = m_length_reg;

    always_comb begin
        state_next      = state_reg;
        count_next      = count_reg;
        rd_next         = rd_reg;
        pos_next        = pos_reg;
        value_next      = value_reg;
        is_ins_next     = is_ins_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        m_valid_next    = m_valid_reg && !m_ready;
        m_value_next    = m_value_reg;
        m_status_next   = m_status_reg;
        m_length_next   = m_length_reg;
        q_pop           = 1'b0;
        mem_re          = 1'b0;
        mem_raddr       = rd_reg;
        // The data of a read issued during a shift is written back in the cycle after the read.
        mem_we          = pend_reg;
        mem_waddr       = pend_addr_reg;
        mem_wdata       = rdata_reg;

        unique case (state_reg)
            BK_IDLE: begin
                if (q_valid) begin
                    q_pop           = 1'b1;
                    value_next      = q_req.value;
                    pos_next        = req_pos_x[AW-1:0];
                    res_value_next  = '0;
                    res_status_next = STAT_OK;
                    unique case (q_req.op)
                        OP_INSERT: begin
                            is_ins_next = 1'b1;
                            if (req_pos_x > count_x) begin
                                res_status_next = STAT_RANGE;
                                state_next      = BK_DONE;
                            end else if (count_reg == CAP_CNT) begin
                                res_status_next = STAT_FULL;
                                state_next      = BK_DONE;
                            end else if (req_pos_x == count_x) begin
                                state_next = BK_PUT;
                            end else begin
                                rd_next    = count_m1[AW-1:0];
                                state_next = BK_SHIFT;
                            end
                        end
                        OP_DELETE: begin
                            is_ins_next = 1'b0;
                            if (req_pos_x >= count_x) begin
                                res_status_next = STAT_RANGE;
                                state_next      = BK_DONE;
                            end else if (req_pos_p1 < count_x) begin
                                rd_next    = req_pos_p1[AW-1:0];
                                state_next = BK_SHIFT;
                            end else begin
                                count_next = count_m1;
                                state_next = BK_DONE;
                            end
                        end
                        OP_READ: begin
                            if (req_pos_x < count_x) begin
                                mem_re     = 1'b1;
                                mem_raddr  = req_pos_x[AW-1:0];
                                state_next = BK_RWAIT;
                            end else begin
                                res_status_next = STAT_RANGE;
                                state_next      = BK_DONE;
                            end
                        end
                        default: begin
                            res_status_next = STAT_RANGE;
                            state_next      = BK_DONE;
                        end
                    endcase
                end
            end
            BK_SHIFT: begin
                mem_re    = 1'b1;
                mem_raddr = rd_reg;
                pend_next = 1'b1;
                if (is_ins_reg) begin
                    pend_addr_next = rd_reg + AW'(1);
                    if (rd_reg == pos_reg) begin
                        state_next = BK_DRAIN;
                    end else begin
                        rd_next = rd_reg - AW'(1);
                    end
                end else begin
                    pend_addr_next = rd_reg - AW'(1);
                    if (rd_reg == count_m1[AW-1:0]) begin
                        state_next = BK_DRAIN;
                    end else begin
                        rd_next = rd_reg + AW'(1);
                    end
                end
            end
            BK_DRAIN: begin
                if (is_ins_reg) begin
                    state_next = BK_PUT;
                end else begin
                    count_next = count_m1;
                    state_next = BK_DONE;
                end
            end
            BK_PUT: begin
                mem_we     = 1'b1;
                mem_waddr  = pos_reg;
                mem_wdata  = value_reg;
                count_next = count_reg + CW'(1);
                state_next = BK_DONE;
            end
            BK_RWAIT: begin
                res_value_next = rdata_reg;
                state_next     = BK_DONE;
            end
            BK_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_value_next  = res_value_reg;
                    m_status_next = res_status_reg;
                    m_length_next = count_x[LEN_W-1:0];
                    state_next    = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            count_reg   <= '0;
            pend_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg         <= rd_next;
        pos_reg        <= pos_next;
        value_reg      <= value_next;
        is_ins_reg     <= is_ins_next;
        pend_addr_reg  <= pend_addr_next;
        res_value_reg  <= res_value_next;
        res_status_reg <= res_status_next;
        m_value_reg    <= m_value_next;
        m_status_reg   <= m_status_next;
        m_length_reg   <= m_length_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re) begin
            rdata_reg <= mem[mem_raddr];
        end
    end

endmodule

`default_nettype wire

>>> src/indexed_ordered_list.sv
// ----------------------------------------------------------------------------
// indexed_ordered_list: bounded ordered list of signed 32-bit values
// Commands insert, delete and read by list position; each gives one result.
// ----------------------------------------------------------------------------
// Usage:
// The s_ channel carries one command per transfer: insert at head, insert
// at tail, insert at a position, delete at a position, or read. The m_
// channel returns exactly one result per command, in order: the value read
// (zero unless a read succeeds), a status (ok, position out of range, list
// full) and the list length after the command.
// Commands pass through a two-entry queue, so the source can hand over new
// commands while the engine is busy and while a result waits for m_ready.
// A rejected command, a read, an insert at the end and a delete of the last
// entry move no entries. Any other insert moves every entry from its
// position up (length minus position entries), and any other delete moves
// every entry above its position down. The engine works on one command at
// a time, and the moves are paced by the single read and write memory ports.
// Reset empties the list at once (length zero, no clearing pass) and drops
// any queued commands and any pending result. When the receiver holds
// m_ready low the result register holds its transfer, the engine waits
// with the next result, and the queue fills before s_ready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module indexed_ordered_list
    import iol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    s_valid,
    output logic                         s_ready,
    input  wire logic [CMD_W-1:0]        s_command,
    input  wire logic [POS_W-1:0]        s_position,
    input  wire logic signed [VAL_W-1:0] s_value,
    output logic                         m_valid,
    input  wire logic                    m_ready,
    output logic signed [VAL_W-1:0]      m_read_value,
    output logic [ST_W-1:0]              m_status,
    output logic [LEN_W-1:0]             m_length
);

    // Decoded requests between the intake and the list engine.
    logic push;
    req_t push_req;
    logic q_full;
    logic q_valid;
    req_t q_req;
    logic q_pop;

    iol_front u_front (
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_command  (s_command),
        .s_position (s_position),
        .s_value    (s_value),
        .q_full     (q_full),
        .push       (push),
        .push_req   (push_req)
    );

    iol_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_req  (push_req),
        .full      (q_full),
        .out_valid (q_valid),
        .out_req   (q_req),
        .pop       (q_pop)
    );

    // The engine owns the entry memory, the length and the result register.
    iol_back #(
        .CAPACITY (CAPACITY)
    ) u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (q_valid),
        .q_req        (q_req),
        .q_pop        (q_pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_value (m_read_value),
        .m_status     (m_status),
        .m_length     (m_length)
    );

endmodule

`default_nettype wire

>>> src/iol_checker.sv
// ----------------------------------------------------------------------------
// iol_checker: result channel checks
// Watches the result ports of the list and flags impossible results.
// ----------------------------------------------------------------------------
`default_nettype none

module iol_checker
    import iol_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
) (
    input wire logic                    aclk,
    input wire logic                    aresetn,
    input wire logic                    m_valid,
    input wire logic                    m_ready,
    input wire logic signed [VAL_W-1:0] m_read_value,
    input wire logic [ST_W-1:0]         m_status,
    input wire logic [LEN_W-1:0]        m_length
);

    localparam logic [LEN_W-1:0] CAP_LEN = LEN_W'(CAPACITY);
    localparam logic             WIDE_CAP = (CAPACITY >= (1 << LEN_W));

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status == STAT_OK || m_status == STAT_RANGE ||
                     m_status == STAT_FULL))
        else $error("result status is not a defined code");

    a_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status != STAT_OK) |-> (m_read_value == '0))
        else $error("failed command returned a nonzero value");

    a_full_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == STAT_FULL) |-> (m_length == CAP_LEN))
        else $error("list full reported below capacity");

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (WIDE_CAP || m_length <= CAP_LEN))
        else $error("length beyond capacity");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_length) &&
                                   $stable(m_status) && $stable(m_read_value)))
        else $error("stalled result changed");

endmodule

bind indexed_ordered_list iol_checker #(
    .CAPACITY (CAPACITY)
) u_iol_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_read_value (m_read_value),
    .m_status     (m_status),
    .m_length     (m_length)
);

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: self-checking testbench for the indexed ordered list
// A short scripted run covers the empty list, the value extremes, every
// command and every rejection. It is followed by about thirteen hundred
// random commands in phases that steer the list length toward a goal: small
// lists, an empty list, and once a completely full list. A behavioral copy
// of the list predicts every result. Both handshakes idle at random, the
// receiver twice holds off long enough to back the block up, and the sender
// lets the block drain at every other phase boundary.
// ----------------------------------------------------------------------------
module tb_top;
    import iol_pkg::*;

    localparam int LIST_CAP     = CAPACITY_DEF;
    localparam int POS_MAX      = (1 << POS_W) - 1;
    localparam int RANDOM_GOAL  = 1330;
    localparam int FILL_PHASE   = 3;
    localparam int FULL_EXTRA   = 30;
    localparam int LONG_HOLD    = 400;
    localparam int HOLD_EVERY   = 400;
    localparam int SETTLE       = 300;
    localparam int CYCLE_LIMIT  = 4_000_000;

    // Command codes that the block does not define; each one must be rejected.
    localparam logic [CMD_W-1:0] CMD_SPARE_A = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SPARE_B = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE_C = 3'd7;

    localparam logic signed [VAL_W-1:0] VMAX = 32'sh7FFF_FFFF;
    localparam logic signed [VAL_W-1:0] VMIN = 32'sh8000_0000;
    localparam logic signed [VAL_W-1:0] VNEG = -32'sd1;
    localparam logic [POS_W-1:0]        PTOP = 9'd511;

    // One result as it appears on the m_ channel.
    typedef struct packed {
        logic signed [VAL_W-1:0] read_value;
        logic [ST_W-1:0]         status;
        logic [LEN_W-1:0]        length;
    } list_answer_t;

    // One scripted command. Where typed is set, want is the result that can
    // be read straight off the command; otherwise the list copy decides.
    typedef struct packed {
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;
        logic                    typed;
        list_answer_t            want;
    } script_row_t;

    // Styles of receiver back-pressure, each held for a random stretch.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_COMB
    } rx_style_t;

    localparam list_answer_t NO_WANT = '0;
    localparam int SCRIPT_LEN = 24;

    // The scripted opening. It starts on the empty list, where every read,
    // delete and out-of-range insert is rejected, then builds a four-entry
    // list out of the value extremes with each insert flavor (including an
    // insert exactly at the length), reads it back, probes positions just
    // past the end and at the top of the field, then deletes from the middle
    // and from the tail, reads, and inserts at the head and deletes it again.
    localparam script_row_t SCRIPT [SCRIPT_LEN] = '{
        '{CMD_READ,     9'd0,     32'sd0,        1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{CMD_DELETE,   9'd0,     32'sd0,        1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{CMD_INS_POS,  9'd1,     32'sd1,        1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{CMD_SPARE_A,  9'd0,     32'sd0,        1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{CMD_SPARE_B,  PTOP,     VNEG,          1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{CMD_SPARE_C,  9'h155,   32'sh5555_5555, 1'b1, '{32'sd0, STAT_RANGE, 9'd0}},
        '{CMD_INS_HEAD, PTOP,     VMAX,          1'b1, '{32'sd0, STAT_OK,    9'd1}},
        '{CMD_INS_TAIL, 9'h0AA,   VMIN,          1'b1, '{32'sd0, STAT_OK,    9'd2}},
        '{CMD_INS_POS,  9'd1,     VNEG,          1'b1, '{32'sd0, STAT_OK,    9'd3}},
        '{CMD_INS_POS,  9'd3,     32'sd0,        1'b1, '{32'sd0, STAT_OK,    9'd4}},
        '{CMD_INS_POS,  9'd5,     32'sd7,        1'b1, '{32'sd0, STAT_RANGE, 9'd4}},
        '{CMD_INS_POS,  PTOP,     32'shAAAA_AAAA, 1'b1, '{32'sd0, STAT_RANGE, 9'd4}},
        '{CMD_READ,     9'd0,     32'sd0,        1'b1, '{VMAX,    STAT_OK,    9'd4}},
        '{CMD_READ,     9'd1,     VMAX,          1'b1, '{VNEG,    STAT_OK,    9'd4}},
        '{CMD_READ,     9'd2,     32'sd0,        1'b1, '{VMIN,    STAT_OK,    9'd4}},
        '{CMD_READ,     9'd3,     VNEG,          1'b1, '{32'sd0,  STAT_OK,    9'd4}},
        '{CMD_READ,     9'd4,     32'sd0,        1'b1, '{32'sd0,  STAT_RANGE, 9'd4}},
        '{CMD_READ,     PTOP,     32'sd0,        1'b1, '{32'sd0,  STAT_RANGE, 9'd4}},
        '{CMD_DELETE,   9'd4,     32'sd0,        1'b1, '{32'sd0,  STAT_RANGE, 9'd4}},
        '{CMD_DELETE,   9'd1,     VMIN,          1'b0, NO_WANT},
        '{CMD_DELETE,   9'd2,     32'sd0,        1'b0, NO_WANT},
        '{CMD_READ,     9'd1,     32'sd0,        1'b0, NO_WANT},
        '{CMD_INS_HEAD, 9'd0,     32'sh1234_5678, 1'b0, NO_WANT},
        '{CMD_DELETE,   9'd0,     32'sd0,        1'b0, NO_WANT}
    };

    // Clock, reset and the block's ports. Every input has a known value
    // from time zero on.
    logic                    aclk;
    logic                    aresetn    = 1'b0;
    logic                    s_valid    = 1'b0;
    logic                    s_ready;
    logic [CMD_W-1:0]        s_command  = CMD_READ;
    logic [POS_W-1:0]        s_position = '0;
    logic signed [VAL_W-1:0] s_value    = '0;
    logic                    m_valid;
    logic                    m_ready    = 1'b0;
    logic signed [VAL_W-1:0] m_read_value;
    logic [ST_W-1:0]         m_status;
    logic [LEN_W-1:0]        m_length;

    // Behavioral copy of the list: slot contents and the current length.
    logic signed [VAL_W-1:0] slot_val [LIST_CAP];
    int                      list_len  = 0;
    int                      peak_len  = 0;

    // Results still owed by the block, oldest first.
    list_answer_t answers_due [$];

    int errors       = 0;
    int issued       = 0;
    int results_seen = 0;
    int burst_left   = 0;
    int cycles       = 0;
    int status_tally [4];

    indexed_ordered_list #(
        .CAPACITY(LIST_CAP)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_command   (s_command),
        .s_position  (s_position),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_read_value(m_read_value),
        .m_status    (m_status),
        .m_length    (m_length)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Applies one command to the list copy and returns the result the block
    // owes for it. An insert checks its position before it checks for a full
    // list, so a position past the end is reported as out of range even when
    // the list is full. Undefined command codes leave the list alone.
    function automatic list_answer_t list_apply(input logic [CMD_W-1:0] cmd,
                                                input logic [POS_W-1:0] pos,
                                                input logic signed [VAL_W-1:0] val);
        list_answer_t ans;
        int           at;
        int           i;
        bit           is_insert;
        ans.read_value = '0;
        ans.status     = STAT_RANGE;
        is_insert      = 1'b0;
        at             = int'(pos);
        case (cmd)
            CMD_INS_HEAD: begin
                is_insert = 1'b1;
                at        = 0;
            end
            CMD_INS_TAIL: begin
                is_insert = 1'b1;
                at        = list_len;
            end
            CMD_INS_POS: begin
                is_insert = 1'b1;
            end
            CMD_DELETE: begin
                if (at < list_len) begin
                    for (i = at; i + 1 < list_len; i++) begin
                        slot_val[i] = slot_val[i + 1];
                    end
                    list_len--;
                    ans.status = STAT_OK;
                end
            end
            CMD_READ: begin
                if (at < list_len) begin
                    ans.read_value = slot_val[at];
                    ans.status     = STAT_OK;
                end
            end
            default: begin
            end
        endcase
        if (is_insert) begin
            if (at > list_len) begin
                ans.status = STAT_RANGE;
            end else if (list_len >= LIST_CAP) begin
                ans.status = STAT_FULL;
            end else begin
                for (i = list_len; i > at; i--) begin
                    slot_val[i] = slot_val[i - 1];
                end
                slot_val[at] = val;
                list_len++;
                ans.status = STAT_OK;
            end
        end
        if (list_len > peak_len) begin
            peak_len = list_len;
        end
        ans.length = LEN_W'(list_len);
        return ans;
    endfunction

    // Offers one command and waits for its transfer. The sender runs in
    // bursts: when a burst is used up it may drop valid for a random gap
    // before the next one starts. Valid is only lowered in a step where it
    // is not raised again, so a zero gap simply keeps it high.
    task automatic send_command(input logic [CMD_W-1:0] cmd,
                                input logic [POS_W-1:0] pos,
                                input logic signed [VAL_W-1:0] val,
                                input bit typed,
                                input list_answer_t want);
        list_answer_t predicted;
        int           gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid    <= 1'b1;
        s_command  <= cmd;
        s_position <= pos;
        s_value    <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        // The transfer happened at this edge, so the list copy moves on now.
        predicted = list_apply(cmd, pos, val);
        answers_due.push_back(typed ? want : predicted);
        issued++;
    endtask

    // Draws one random command. The mix of inserts and deletes pulls the
    // list length toward goal_len; at the goal it wanders around it. Most
    // positions fall in or just past the list, a few anywhere in the field.
    task automatic draw_command(input int goal_len,
                                output logic [CMD_W-1:0] cmd,
                                output logic [POS_W-1:0] pos,
                                output logic signed [VAL_W-1:0] val);
        int dice;
        int ins_share;
        int del_share;
        if (list_len < goal_len) begin
            ins_share = 75;
            del_share = 10;
        end else if (list_len > goal_len) begin
            ins_share = 5;
            del_share = 85;
        end else begin
            ins_share = 35;
            del_share = 30;
        end
        dice = $urandom_range(0, 99);
        if (dice < 3) begin
            cmd = CMD_W'($urandom_range(CMD_SPARE_A, CMD_SPARE_C));
        end else begin
            dice = $urandom_range(0, 99);
            if (dice < ins_share) begin
                case ($urandom_range(0, 3))
                    0:       cmd = CMD_INS_HEAD;
                    1:       cmd = CMD_INS_TAIL;
                    default: cmd = CMD_INS_POS;
                endcase
            end else if (dice < ins_share + del_share) begin
                cmd = CMD_DELETE;
            end else begin
                cmd = CMD_READ;
            end
        end
        if ($urandom_range(0, 9) == 0) begin
            pos = POS_W'($urandom_range(0, POS_MAX));
        end else begin
            pos = POS_W'($urandom_range(0, list_len));
        end
        if ($urandom_range(0, 15) == 0) begin
            case ($urandom_range(0, 3))
                0:       val = VMAX;
                1:       val = VMIN;
                2:       val = '0;
                default: val = VNEG;
            endcase
        end else begin
            val = $urandom;
        end
    endtask

    // Lets the block drain: valid drops and the sender waits until every
    // owed result has been taken. At least one edge passes, so valid never
    // falls and rises within the same step.
    task automatic wait_drained();
        s_valid    <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (answers_due.size() != 0);
    endtask

    // Compares one result transfer with the oldest owed result.
    task automatic verify_answer(input logic signed [VAL_W-1:0] rd,
                                 input logic [ST_W-1:0] st,
                                 input logic [LEN_W-1:0] len);
        list_answer_t want;
        results_seen++;
        if (answers_due.size() == 0) begin
            errors++;
            $display("%0t: result with nothing owed: read_value %0d status %0d length %0d",
                     $time, rd, st, len);
        end else begin
            want = answers_due.pop_front();
            status_tally[want.status]++;
            if (rd !== want.read_value) begin
                errors++;
                $display("%0t: read_value expected %0d, got %0d",
                         $time, want.read_value, rd);
            end
            if (st !== want.status) begin
                errors++;
                $display("%0t: status expected %0d, got %0d", $time, want.status, st);
            end
            if (len !== want.length) begin
                errors++;
                $display("%0t: length expected %0d, got %0d", $time, want.length, len);
            end
        end
    endtask

    // Receiver. Results are checked from the values that stood before the
    // edge, then m_ready for the next cycle is chosen. Back-pressure changes
    // style every so often, and every HOLD_EVERY results (twice in the run)
    // the receiver refuses every transfer until its hold runs out, so that the
    // block's queue fills up and s_ready falls while the sender keeps going.
    rx_style_t rx_style   = RX_OPEN;
    int        style_left = 0;
    int        hold_left  = 0;
    int        holds_done = 0;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            verify_answer(m_read_value, m_status, m_length);
        end
        if (holds_done < 2 && results_seen >= (holds_done + 1) * HOLD_EVERY) begin
            holds_done++;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            if (style_left == 0) begin
                rx_style   = rx_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(20, 150);
            end
            style_left--;
            case (rx_style)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 4) == 0);
                default:   m_ready <= ((style_left % 8) < 5);
            endcase
        end
    end

    // Watchdog: a run that has not finished by now has hung.
    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("%0t: timeout after %0d cycles with %0d results still owed",
                     $time, cycles, answers_due.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Sender: reset, the scripted opening, then the random phases.
    initial begin
        int                      row;
        int                      phase;
        int                      goal_len;
        int                      run_len;
        int                      full_extra;
        int                      random_sent;
        bit                      filling;
        logic [CMD_W-1:0]        cmd;
        logic [POS_W-1:0]        pos;
        logic signed [VAL_W-1:0] val;

        for (row = 0; row < 4; row++) begin
            status_tally[row] = 0;
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (row = 0; row < SCRIPT_LEN; row++) begin
            send_command(SCRIPT[row].cmd, SCRIPT[row].pos, SCRIPT[row].val,
                         SCRIPT[row].typed, SCRIPT[row].want);
        end
        wait_drained();

        // Each phase picks a length goal. One phase fills the list to the
        // brim and keeps pushing for a while, so that inserts run into the
        // full list; the phases after it drain it again.
        random_sent = 0;
        phase = 0;
        while (random_sent < RANDOM_GOAL) begin
            filling = (phase == FILL_PHASE);
            if (filling) begin
                goal_len = LIST_CAP;
            end else begin
                case ($urandom_range(0, 3))
                    0:       goal_len = 0;
                    1:       goal_len = $urandom_range(1, 6);
                    2:       goal_len = $urandom_range(6, 24);
                    default: goal_len = $urandom_range(24, 64);
                endcase
            end
            run_len    = $urandom_range(30, 90);
            full_extra = 0;
            while (random_sent < RANDOM_GOAL &&
                   (filling ? (full_extra < FULL_EXTRA) : (run_len > 0))) begin
                draw_command(goal_len, cmd, pos, val);
                send_command(cmd, pos, val, 1'b0, NO_WANT);
                random_sent++;
                run_len--;
                if (filling && list_len == LIST_CAP) begin
                    full_extra++;
                end
            end
            // Every other phase boundary the sender waits for the block to
            // empty out completely before it goes on.
            if (phase % 2 == 1) begin
                wait_drained();
            end
            phase++;
        end

        wait_drained();
        // Anything the block sends after this point has no owner.
        repeat (SETTLE) @(posedge aclk);

        $display("Checked %0d results of %0d commands over %0d phases; longest list %0d.",
                 results_seen, issued, phase, peak_len);
        $display("Status mix: %0d ok, %0d out of range, %0d list full; %0d mismatches.",
                 status_tally[STAT_OK], status_tally[STAT_RANGE],
                 status_tally[STAT_FULL], errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

>>> files.f
src/iol_pkg.sv
src/iol_front.sv
src/iol_queue.sv
src/iol_back.sv
src/indexed_ordered_list.sv
src/iol_checker.sv
verif/tb_top.sv
